// File: src/pgtk_pkg.sv
// Shared constants and types for the per-group top-k prefilter.
// No dependencies; used by pgtk_scan and per_group_top_k_prefilter.
package pgtk_pkg;

	localparam int GROUPS_DEF = 256;
	localparam int K_MAX_DEF  = 16;
	localparam int KEY_W      = 8;   // group_index width
	localparam int VAL_W      = 32;  // sort_value width
	localparam int CFG_W      = 5;   // k_keep width
	localparam logic [CFG_W-1:0] K_KEEP_RST = CFG_W'(1);
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// scan unit control: first loads a fresh element, en accepts one element
	typedef struct packed {
		logic en;
		logic first;
	} scan_ctl_t;

endpackage

// File: src/pgtk_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pgtk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/pgtk_scan.sv
// Streaming largest / second-largest tracker over a group's kept values.
// Depends on pgtk_pkg (scan_ctl_t, VAL_W, VAL_MIN).
module pgtk_scan #(
	parameter int IW = 4
) (
	input  logic                               clk,
	input  pgtk_pkg::scan_ctl_t                ctl,
	input  logic [IW-1:0]                      idx,
	input  logic signed [pgtk_pkg::VAL_W-1:0]  data,
	output logic [IW-1:0]                      top_idx,
	output logic signed [pgtk_pkg::VAL_W-1:0]  runner_up
);

	logic signed [pgtk_pkg::VAL_W-1:0] top_q;
	logic signed [pgtk_pkg::VAL_W-1:0] second_q;
	logic [IW-1:0]                     top_idx_q;

	// first occurrence of the largest wins (strict >); second_q is the
	// largest of everything except that entry
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.first) begin
				top_q     <= data;
				top_idx_q <= idx;
				second_q  <= pgtk_pkg::VAL_MIN;
			end else if (data > top_q) begin
				second_q  <= top_q;
				top_q     <= data;
				top_idx_q <= idx;
			end else if (data > second_q) begin
				second_q  <= data;
			end
		end
	end

	assign top_idx   = top_idx_q;
	assign runner_up = second_q;

endmodule

// File: src/per_group_top_k_prefilter.sv
// Top level of the per-group top-k prefilter: sequencer, config register, memories.
// Depends on pgtk_pkg, pgtk_ram and pgtk_scan.
//
//  channel   | signals                          | handshake
//  ----------+----------------------------------+---------------------------------
//  request   | group_index, sort_value          | start & !busy accepts
//  result    | keep_row                         | done strobe, one cycle, no stall
//  config    | cfg_data (k_keep)                | cfg_valid & cfg_ready
//
// A failing row, or a row into a group that is not yet full, finishes in CHECK. A
// passing row into a full group goes on through SCAN and PLACE: the kept-value
// RAM is walked one entry per cycle through its single read port. The next
// request is taken in the cycle that done is high.
// After reset the group table is cleared, one group per cycle, with busy high;
// config writes are taken throughout. The receiver cannot stall.
module per_group_top_k_prefilter #(
	parameter int GROUPS = pgtk_pkg::GROUPS_DEF,
	parameter int K_MAX  = pgtk_pkg::K_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [pgtk_pkg::KEY_W-1:0]         group_index,
	input  logic signed [pgtk_pkg::VAL_W-1:0]  sort_value,
	output logic                               done,
	output logic                               keep_row,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pgtk_pkg::CFG_W-1:0]         cfg_data
);

	localparam int VW   = pgtk_pkg::VAL_W;
	localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int FW   = $clog2(K_MAX + 1);               // fill count width
	localparam int IW   = (K_MAX > 1) ? $clog2(K_MAX) : 1; // slot index width
	localparam int KD   = GROUPS * K_MAX;
	localparam int KAW  = (KD > 1) ? $clog2(KD) : 1;
	localparam int MW   = FW + VW;                         // {fill, maximum}
	localparam int KCW  = (pgtk_pkg::CFG_W > FW) ? pgtk_pkg::CFG_W : FW;
	localparam int KEYS = 2 ** pgtk_pkg::KEY_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_PLACE
	} state_t;

	state_t state_q;

	// group index wrapped modulo GROUPS, built at elaboration
	logic [GW-1:0] wrap_tab [KEYS];
	for (genvar gi = 0; gi < KEYS; gi++) begin : g_wrap
		assign wrap_tab[gi] = GW'(gi % GROUPS);
	end

	// configuration
	logic [pgtk_pkg::CFG_W-1:0] k_keep_q;
	logic [KCW-1:0]             k_ext;
	logic [FW-1:0]              k_eff;

	assign cfg_ready = 1'b1;
	assign k_ext     = KCW'(k_keep_q);

	// saturate k into 1..K_MAX
	always_comb begin
		if (k_ext == '0) begin
			k_eff = FW'(1);
		end else if (k_ext > KCW'(K_MAX)) begin
			k_eff = FW'(K_MAX);
		end else begin
			k_eff = FW'(k_ext);
		end
	end

	// request registers
	logic [GW-1:0]          g_q;
	logic signed [VW-1:0]   v_q;
	logic [KAW-1:0]         base_q;
	logic [FW-1:0]          fill_q;
	logic [FW-1:0]          cnt_q;
	logic [GW-1:0]          clr_q;
	logic                   rvld_s1;
	logic [IW-1:0]          ridx_s1;
	logic                   keep_q;
	logic                   done_q;

	logic                   accept;
	logic [GW-1:0]          g_in;

	assign accept = start && (state_q == ST_IDLE);
	assign g_in   = wrap_tab[group_index];

	// group table: fill count and maximum per group
	logic            meta_we;
	logic [GW-1:0]   meta_waddr;
	logic [MW-1:0]   meta_wdata;
	logic [GW-1:0]   meta_raddr;
	logic [MW-1:0]   meta_rdata;

	// kept values: K_MAX slots per group, unordered
	logic            kept_we;
	logic [KAW-1:0]  kept_waddr;
	logic [VW-1:0]   kept_wdata;
	logic [KAW-1:0]  kept_raddr;
	logic [VW-1:0]   kept_rdata;

	logic [FW-1:0]          rd_fill;
	logic signed [VW-1:0]   rd_max;
	logic signed [VW-1:0]   ins_max;
	logic signed [VW-1:0]   place_max;
	logic                   scan_issue;
	logic                   row_done;

	pgtk_pkg::scan_ctl_t    scan_ctl;
	logic [IW-1:0]          top_idx;
	logic signed [VW-1:0]   runner_up;

	assign rd_fill    = meta_rdata[MW-1:VW];
	assign rd_max     = meta_rdata[VW-1:0];
	assign ins_max    = (v_q > rd_max) ? v_q : rd_max;
	assign place_max  = (v_q > runner_up) ? v_q : runner_up;
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q != fill_q);

	// result is ready at the end of CHECK (append or reject) or of PLACE
	assign row_done = ((state_q == ST_CHECK) && ((rd_fill < k_eff) || (v_q > rd_max)))
		|| (state_q == ST_PLACE);

	assign meta_raddr = accept ? g_in : g_q;
	assign kept_raddr = base_q + KAW'(cnt_q[IW-1:0]);
	assign kept_wdata = v_q;

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = g_q;
		meta_wdata = {rd_fill + FW'(1), ins_max};
		kept_we    = 1'b0;
		kept_waddr = base_q + KAW'(rd_fill[IW-1:0]);
		case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = {{FW{1'b0}}, pgtk_pkg::VAL_MIN};
			end
			ST_CHECK: begin
				// group not full yet: append to the next free slot
				if (rd_fill < k_eff) begin
					meta_we = 1'b1;
					kept_we = 1'b1;
				end
			end
			ST_PLACE: begin
				// overwrite the largest and take the new maximum
				meta_we    = 1'b1;
				meta_wdata = {fill_q, place_max};
				kept_we    = 1'b1;
				kept_waddr = base_q + KAW'(top_idx);
			end
			default: begin
			end
		endcase
	end

	assign scan_ctl.en    = rvld_s1;
	assign scan_ctl.first = rvld_s1 && (ridx_s1 == '0);

	pgtk_ram #(
		.WIDTH (MW),
		.DEPTH (GROUPS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	pgtk_ram #(
		.WIDTH (VW),
		.DEPTH (KD)
	) u_kept_ram (
		.clk   (clk),
		.we    (kept_we),
		.waddr (kept_waddr),
		.wdata (kept_wdata),
		.raddr (kept_raddr),
		.rdata (kept_rdata)
	);

	pgtk_scan #(
		.IW (IW)
	) u_scan (
		.clk       (clk),
		.ctl       (scan_ctl),
		.idx       (ridx_s1),
		.data      (kept_rdata),
		.top_idx   (top_idx),
		.runner_up (runner_up)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_keep_q <= pgtk_pkg::K_KEEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			k_keep_q <= cfg_data;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			g_q    <= g_in;
			v_q    <= sort_value;
			base_q <= KAW'(g_in) * KAW'(K_MAX);
		end
		if (state_q == ST_CHECK) begin
			fill_q <= rd_fill;
		end
		ridx_s1 <= cnt_q[IW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
			keep_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= row_done;
			rvld_s1 <= scan_issue;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GROUPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (rd_fill < k_eff) begin
						keep_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (v_q <= rd_max) begin
						state_q <= ST_SCAN;
					end else begin
						keep_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// last read data is absorbed by the scan unit at this edge
					if (scan_issue) begin
						cnt_q <= cnt_q + FW'(1);
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					keep_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign keep_row = keep_q;

endmodule
